### hdl/adcp_pkg.sv
// Package for the audio DSP command port: field widths, codes and helpers.
// No dependencies; used by every module in hdl.
package adcp_pkg;

   localparam int ReplyDepth = 4;
   localparam int ReplyCntW  = $clog2(ReplyDepth + 1);
   localparam int ReplyIdxW  = $clog2(ReplyDepth);

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_IRQ   = 2'd2;

   localparam logic [15:0] OFF_MIX_IDX  = 16'h0004;
   localparam logic [15:0] OFF_MIX_DATA = 16'h0005;
   localparam logic [15:0] OFF_RESET    = 16'h0006;
   localparam logic [15:0] OFF_READ     = 16'h000A;
   localparam logic [15:0] OFF_CMD      = 16'h000C;
   localparam logic [15:0] OFF_STATUS   = 16'h000E;
   localparam logic [15:0] OFF_ACK16    = 16'h000F;
   localparam logic [15:0] OFF_ACKMPU   = 16'h0010;

   localparam logic [7:0] MIX_IRQ_STATUS = 8'h82;
   localparam logic [7:0] READY_BYTE     = 8'hAA;

   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_MAJOR = 2'd1;
   localparam logic [1:0] CSR_MINOR = 2'd2;

   localparam logic [7:0] CMD_DIRECT   = 8'h10;
   localparam logic [7:0] CMD_COUNT_A  = 8'h14;
   localparam logic [7:0] CMD_ADC      = 8'h20;
   localparam logic [7:0] CMD_COUNT_B  = 8'h24;
   localparam logic [7:0] CMD_TCONST   = 8'h40;
   localparam logic [7:0] CMD_RATE_A   = 8'h41;
   localparam logic [7:0] CMD_RATE_B   = 8'h42;
   localparam logic [7:0] CMD_BLOCK    = 8'h48;
   localparam logic [7:0] CMD_COUNT_C  = 8'h80;
   localparam logic [7:0] CMD_MODE_LO  = 8'hB0;
   localparam logic [7:0] CMD_MODE_HI  = 8'hCF;
   localparam logic [7:0] CMD_SPK_ON   = 8'hD1;
   localparam logic [7:0] CMD_SPK_OFF  = 8'hD3;
   localparam logic [7:0] CMD_SPK_GET  = 8'hD8;
   localparam logic [7:0] CMD_VERSION  = 8'hE1;

   // Engine commands without parameter bytes.
   localparam logic [7:0] CMD_AUTO_OUT8   = 8'h1C;
   localparam logic [7:0] CMD_AUTO_IN8    = 8'h2C;
   localparam logic [7:0] CMD_HS_AUTO_OUT = 8'h90;
   localparam logic [7:0] CMD_HS_OUT      = 8'h91;
   localparam logic [7:0] CMD_HS_AUTO_IN  = 8'h98;
   localparam logic [7:0] CMD_HS_IN       = 8'h99;
   localparam logic [7:0] CMD_MONO_IN     = 8'hA0;
   localparam logic [7:0] CMD_STEREO_IN   = 8'hA8;
   localparam logic [7:0] CMD_PAUSE8      = 8'hD0;
   localparam logic [7:0] CMD_RESUME8     = 8'hD4;
   localparam logic [7:0] CMD_PAUSE16     = 8'hD5;
   localparam logic [7:0] CMD_RESUME16    = 8'hD6;
   localparam logic [7:0] CMD_EXIT16      = 8'hD9;
   localparam logic [7:0] CMD_EXIT8       = 8'hDA;

   // Kind of work handed from the front end to the back end.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ,
      OP_IRQ,
      OP_RESET_DONE,
      OP_EXEC
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [15:0] off;
      logic [7:0]  cmd;
      logic [7:0]  p0;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [7:0]  adc;
      logic [2:0]  raise;
   } job_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        dac_valid;
      logic [7:0]  dac_sample;
      logic        engine_cmd_valid;
      logic [7:0]  engine_cmd;
      logic [7:0]  engine_mode;
      logic [15:0] transfer_count;
      logic [7:0]  sampling_tc;
      logic [15:0] sample_rate;
      logic [15:0] block_size;
      logic        speaker_on;
      logic        irq_line;
   } rsp_type;

   function automatic logic is_mode_cmd(input logic [7:0] c);
      return (c >= CMD_MODE_LO && c <= CMD_MODE_HI);
   endfunction

   function automatic logic is_count_cmd(input logic [7:0] c);
      return (c == CMD_COUNT_A || c == CMD_COUNT_B || c == CMD_COUNT_C);
   endfunction

   function automatic logic [1:0] param_need(input logic [7:0] c);
      logic [1:0] n;
      n = 2'd0;
      if (c == CMD_DIRECT || c == CMD_TCONST) n = 2'd1;
      else if (is_count_cmd(c) || c == CMD_RATE_A ||
               c == CMD_RATE_B || c == CMD_BLOCK) n = 2'd2;
      else if (is_mode_cmd(c)) n = 2'd3;
      return n;
   endfunction

   function automatic logic is_plain_engine(input logic [7:0] c);
      logic r;
      unique case (c)
         CMD_AUTO_OUT8, CMD_AUTO_IN8, CMD_HS_AUTO_OUT, CMD_HS_OUT,
         CMD_HS_AUTO_IN, CMD_HS_IN, CMD_MONO_IN, CMD_STEREO_IN,
         CMD_PAUSE8, CMD_RESUME8, CMD_PAUSE16, CMD_RESUME16,
         CMD_EXIT16, CMD_EXIT8: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### hdl/audio_dsp_command_port.sv
// Audio DSP command port, device side. Depends on adcp_pkg, adcp_front,
// adcp_queue and adcp_back.
// The result of a transaction passes through the job queue and then the result
// register before it can be taken.
// Throughput: one transaction per cycle while the job queue has room.
// Reset: synchronous, active high; control state and settings cleared, CSRs set to defaults.
module audio_dsp_command_port (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   // req_tdata: io_address[15:0], write_data[23:16], adc_sample[31:24],
   // raise_mask[34:32], zero fill to 40 bits
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tuser: dac_valid[0], engine_cmd_valid[1]
   output logic [1:0]  rsp_tuser,
   // rsp_tdata: read_data[7:0], dac_sample[15:8], engine_cmd[23:16],
   // engine_mode[31:24], transfer_count[47:32], sampling_tc[55:48],
   // sample_rate[71:56], block_size[87:72], speaker_on[88], irq_line[89];
   // zero fill to 96 bits
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] base_ff;
   logic [7:0]  major_ff, minor_ff;
   logic        fj_valid, fj_ready, bj_valid, bj_ready;
   adcp_pkg::job_type fj, bj, fj_fix;
   adcp_pkg::rsp_type rsp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 16'd544;
         major_ff <= 8'd4;
         minor_ff <= 8'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            adcp_pkg::CSR_BASE:  base_ff  <= csr_wdata;
            adcp_pkg::CSR_MAJOR: major_ff <= csr_wdata[7:0];
            adcp_pkg::CSR_MINOR: minor_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   adcp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .action(req_tuser), .io_address(req_tdata[15:0]),
      .write_data(req_tdata[23:16]), .adc_sample(req_tdata[31:24]),
      .raise_mask(req_tdata[34:32]), .base_port(base_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   // A mixer index write carries its byte in the first parameter slot.
   always_comb begin
      fj_fix = fj;
      if (fj.op == adcp_pkg::OP_EXEC && fj.off == adcp_pkg::OFF_MIX_IDX)
         fj_fix.p0 = req_tdata[23:16];
   end

   adcp_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj_fix),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
   );

   adcp_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .version_major(major_ff), .version_minor(minor_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tuser = {rsp.engine_cmd_valid, rsp.dac_valid};
   assign rsp_tdata = {6'd0, rsp.irq_line, rsp.speaker_on, rsp.block_size,
                       rsp.sample_rate, rsp.sampling_tc, rsp.transfer_count,
                       rsp.engine_mode, rsp.engine_cmd, rsp.dac_sample,
                       rsp.read_data};

`ifndef ASSERT_OFF
   a_dac_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.dac_valid |-> rsp.dac_sample == 8'd0)
      else $error("dac sample without valid");
   a_eng_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.engine_cmd_valid |-> rsp.engine_cmd == 8'd0)
      else $error("engine command without valid");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tuser, rsp_tdata}))
      else $error("result changed while stalled");
`endif

endmodule

### hdl/adcp_front.sv
// Front end: decodes bus accesses, runs the command parser and emits jobs.
// Depends on adcp_pkg.
module adcp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           action,
   input  logic [15:0]          io_address,
   input  logic [7:0]           write_data,
   input  logic [7:0]           adc_sample,
   input  logic [2:0]           raise_mask,
   input  logic [15:0]          base_port,
   output logic                 job_valid,
   input  logic                 job_ready,
   output adcp_pkg::job_type    job
);

   logic       in_reset_ff, in_reset_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [1:0] left_ff, left_in;
   logic [7:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [15:0] off;
   logic [1:0] idx;
   logic       fire;

   assign in_ready  = job_ready;
   assign job_valid = in_valid;
   assign fire      = in_valid && job_ready;
   assign off       = io_address - base_port;
   assign idx       = adcp_pkg::param_need(cmd_ff) - left_ff;

   always_comb begin
      in_reset_in = in_reset_ff;
      cmd_in      = cmd_ff;
      left_in     = left_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      job.op      = adcp_pkg::OP_NONE;
      job.off     = off;
      job.adc     = adc_sample;
      job.raise   = raise_mask;
      if (action == adcp_pkg::ACT_READ) begin
         job.op = adcp_pkg::OP_READ;
      end else if (action == adcp_pkg::ACT_IRQ) begin
         job.op = adcp_pkg::OP_IRQ;
      end else if (action == adcp_pkg::ACT_WRITE) begin
         if (off == adcp_pkg::OFF_MIX_IDX) begin
            job.op = adcp_pkg::OP_EXEC;  // back end sees offset and sets index
         end else if (off == adcp_pkg::OFF_RESET) begin
            if (write_data[0]) begin
               in_reset_in = 1'b1;
            end else if (in_reset_ff) begin
               in_reset_in = 1'b0;
               cmd_in      = '0;
               left_in     = '0;
               job.op      = adcp_pkg::OP_RESET_DONE;
            end
         end else if (off == adcp_pkg::OFF_CMD && !in_reset_ff) begin
            if (left_ff != 2'd0) begin
               if (idx == 2'd0) p0_in = write_data;
               else if (idx == 2'd1) p1_in = write_data;
               else if (idx == 2'd2) p2_in = write_data;
               left_in = left_ff - 2'd1;
               if (left_ff == 2'd1) job.op = adcp_pkg::OP_EXEC;
            end else begin
               cmd_in  = write_data;
               left_in = adcp_pkg::param_need(write_data);
               if (left_in == 2'd0) job.op = adcp_pkg::OP_EXEC;
            end
         end
      end
      job.cmd = cmd_in;
      job.p0  = p0_in;
      job.p1  = p1_in;
      job.p2  = p2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_reset_ff <= 1'b0;
         cmd_ff      <= '0;
         left_ff     <= '0;
         p0_ff       <= '0;
         p1_ff       <= '0;
         p2_ff       <= '0;
      end else if (fire) begin
         in_reset_ff <= in_reset_in;
         cmd_ff      <= cmd_in;
         left_ff     <= left_in;
         p0_ff       <= p0_in;
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
      end
   end

endmodule

### hdl/adcp_queue.sv
// Two-entry job queue between front end and back end.
// Depends on adcp_pkg.
module adcp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  adcp_pkg::job_type wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output adcp_pkg::job_type rd_job
);

   adcp_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_job   = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### hdl/adcp_back.sv
// Back end: settings, reply queue, interrupt status and the result register.
// Depends on adcp_pkg.
module adcp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  adcp_pkg::job_type job,
   input  logic [7:0]        version_major,
   input  logic [7:0]        version_minor,
   output logic              out_valid,
   input  logic              out_ready,
   output adcp_pkg::rsp_type out_rsp
);

   logic [7:0] rq_ff [adcp_pkg::ReplyDepth];
   logic [7:0] rq_in [adcp_pkg::ReplyDepth];
   logic [adcp_pkg::ReplyCntW-1:0] rc_ff, rc_in;
   logic [7:0]  mix_ff, mix_in;
   logic [2:0]  irq_ff, irq_in;
   logic        spk_ff, spk_in;
   logic [7:0]  tc_ff, tc_in;
   logic [15:0] rate_ff, rate_in, blk_ff, blk_in, cnt_ff, cnt_in;
   logic        valid_ff;
   adcp_pkg::rsp_type rsp_ff, rsp_in;
   logic        fire;
   logic        push_a, push_b;
   logic [7:0]  byte_a, byte_b;
   logic [15:0] lo_first;

   assign job_ready = !valid_ff || out_ready;
   assign fire      = job_valid && job_ready;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;
   assign lo_first  = {job.p1, job.p0};

   always_comb begin
      rc_in   = rc_ff;
      rq_in   = rq_ff;
      mix_in  = mix_ff;
      irq_in  = irq_ff;
      spk_in  = spk_ff;
      tc_in   = tc_ff;
      rate_in = rate_ff;
      blk_in  = blk_ff;
      cnt_in  = cnt_ff;
      push_a  = 1'b0;
      push_b  = 1'b0;
      byte_a  = '0;
      byte_b  = version_minor;
      rsp_in  = '0;
      unique case (job.op)
         adcp_pkg::OP_READ: begin
            unique case (job.off)
               adcp_pkg::OFF_MIX_IDX: rsp_in.read_data = mix_ff;
               adcp_pkg::OFF_MIX_DATA:
                  rsp_in.read_data = (mix_ff == adcp_pkg::MIX_IRQ_STATUS) ?
                                     {5'd0, irq_ff} : 8'h00;
               adcp_pkg::OFF_READ: begin
                  if (rc_ff != '0) begin
                     rsp_in.read_data = rq_ff[0];
                     for (int i = 0; i < adcp_pkg::ReplyDepth - 1; i++)
                        rq_in[i] = rq_ff[i+1];
                     rc_in = rc_ff - adcp_pkg::ReplyCntW'(1);
                  end
               end
               adcp_pkg::OFF_CMD: rsp_in.read_data = 8'h7F;
               adcp_pkg::OFF_STATUS: begin
                  rsp_in.read_data = (rc_ff != '0) ? 8'hFF : 8'h7F;
                  irq_in = irq_ff & 3'b110;
               end
               adcp_pkg::OFF_ACK16: begin
                  rsp_in.read_data = 8'hFF;
                  irq_in = irq_ff & 3'b101;
               end
               adcp_pkg::OFF_ACKMPU: begin
                  rsp_in.read_data = 8'hFF;
                  irq_in = irq_ff & 3'b011;
               end
               default: rsp_in.read_data = 8'hFF;
            endcase
         end
         adcp_pkg::OP_IRQ: irq_in = irq_ff | job.raise;
         adcp_pkg::OP_RESET_DONE: begin
            rq_in[0] = adcp_pkg::READY_BYTE;
            rc_in    = adcp_pkg::ReplyCntW'(1);
         end
         adcp_pkg::OP_EXEC: begin
            if (job.off == adcp_pkg::OFF_MIX_IDX) begin
               mix_in = job.p0;
            end else if (job.cmd == adcp_pkg::CMD_DIRECT) begin
               rsp_in.dac_valid  = 1'b1;
               rsp_in.dac_sample = job.p0;
            end else if (adcp_pkg::is_count_cmd(job.cmd)) begin
               cnt_in = lo_first;
               rsp_in.engine_cmd_valid = 1'b1;
               rsp_in.engine_cmd       = job.cmd;
            end else if (adcp_pkg::is_mode_cmd(job.cmd)) begin
               cnt_in = {job.p2, job.p1};
               rsp_in.engine_cmd_valid = 1'b1;
               rsp_in.engine_cmd       = job.cmd;
               rsp_in.engine_mode      = job.p0;
            end else if (adcp_pkg::is_plain_engine(job.cmd)) begin
               rsp_in.engine_cmd_valid = 1'b1;
               rsp_in.engine_cmd       = job.cmd;
            end else if (job.cmd == adcp_pkg::CMD_ADC) begin
               push_a = 1'b1;
               byte_a = job.adc;
            end else if (job.cmd == adcp_pkg::CMD_TCONST) begin
               tc_in = job.p0;
            end else if (job.cmd == adcp_pkg::CMD_RATE_A ||
                         job.cmd == adcp_pkg::CMD_RATE_B) begin
               rate_in = {job.p0, job.p1};
            end else if (job.cmd == adcp_pkg::CMD_BLOCK) begin
               blk_in = lo_first;
            end else if (job.cmd == adcp_pkg::CMD_SPK_ON) begin
               spk_in = 1'b1;
            end else if (job.cmd == adcp_pkg::CMD_SPK_OFF) begin
               spk_in = 1'b0;
            end else if (job.cmd == adcp_pkg::CMD_SPK_GET) begin
               push_a = 1'b1;
               byte_a = spk_ff ? 8'hFF : 8'h00;
            end else if (job.cmd == adcp_pkg::CMD_VERSION) begin
               push_a = 1'b1;
               push_b = 1'b1;
               byte_a = version_major;
            end
            if (push_a && rc_ff < adcp_pkg::ReplyCntW'(adcp_pkg::ReplyDepth)) begin
               rq_in[rc_ff[adcp_pkg::ReplyIdxW-1:0]] = byte_a;
               rc_in = rc_ff + adcp_pkg::ReplyCntW'(1);
               if (push_b && rc_in < adcp_pkg::ReplyCntW'(adcp_pkg::ReplyDepth)) begin
                  rq_in[rc_in[adcp_pkg::ReplyIdxW-1:0]] = byte_b;
                  rc_in = rc_in + adcp_pkg::ReplyCntW'(1);
               end
            end
         end
         default: ;
      endcase
      rsp_in.transfer_count = cnt_in;
      rsp_in.sampling_tc    = tc_in;
      rsp_in.sample_rate    = rate_in;
      rsp_in.block_size     = blk_in;
      rsp_in.speaker_on     = spk_in;
      rsp_in.irq_line       = (irq_in != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rq_ff  <= rq_in;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rc_ff    <= '0;
         mix_ff   <= '0;
         irq_ff   <= '0;
         spk_ff   <= 1'b0;
         tc_ff    <= '0;
         rate_ff  <= '0;
         blk_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         if (job_ready) valid_ff <= job_valid;
         if (fire) begin
            rc_ff   <= rc_in;
            mix_ff  <= mix_in;
            irq_ff  <= irq_in;
            spk_ff  <= spk_in;
            tc_ff   <= tc_in;
            rate_ff <= rate_in;
            blk_ff  <= blk_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

endmodule
